FILE: rtl/bbs_random_bit_generator_assert.svh
// assertion macros shared by the generator rtl
`ifndef BBS_RANDOM_BIT_GENERATOR_ASSERT_SVH
`define BBS_RANDOM_BIT_GENERATOR_ASSERT_SVH

// checked only out of reset
`define BBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define BBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bbs_pkg.sv
// shared types and constants for the blum blum shub generator
package bbs_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STEP_W  = $clog2(DATA_W);

  typedef logic [DATA_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STEP_W-1:0]  step_t;

  typedef enum logic {
    FUNC_SEED = 1'b0,
    FUNC_DRAW = 1'b1
  } func_t;

  localparam count_t MAX_DRAW_BITS = count_t'(DATA_W);
  localparam word_t  MODULUS_RESET = word_t'(209);

endpackage

FILE: rtl/bbs_sqmod.sv
// bit-serial square-and-reduce unit: shift-add multiply, then restoring modulo unless the modulus is zero
`include "bbs_random_bit_generator_assert.svh"

module bbs_sqmod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bbs_pkg::word_t operand,
  input  bbs_pkg::word_t modulus,
  output logic          done,
  output bbs_pkg::word_t result
);
  import bbs_pkg::*;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_DIV
  } sq_state_t;

  sq_state_t            st_r;
  word_t                mcand_r;
  word_t                mplier_r;
  word_t                prod_r;
  word_t                rem_r;
  step_t                step_r;
  logic                 done_r;
  word_t                result_r;

  word_t                prod_sum;
  logic [DATA_W:0]      trial;
  logic [DATA_W+1:0]    diff;
  word_t                rem_nxt;
  logic                 last_step;

  // product wraps to the word width, as the carry out is dropped
  assign prod_sum  = prod_r + (mplier_r[0] ? mcand_r : '0);
  // next dividend bit comes off the top of the product register
  assign trial     = {rem_r, prod_r[DATA_W-1]};
  assign diff      = {1'b0, trial} - {2'b00, modulus};
  assign rem_nxt   = diff[DATA_W+1] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
  assign last_step = (step_r == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SQ_IDLE;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        SQ_IDLE: begin
          if (start) begin
            mcand_r  <= operand;
            mplier_r <= operand;
            prod_r   <= '0;
            step_r   <= '0;
            st_r     <= SQ_MUL;
          end
        end
        SQ_MUL: begin
          prod_r   <= prod_sum;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          step_r   <= step_r + 1'b1;
          if (last_step) begin
            if (modulus == '0) begin
              // zero modulus: no reduction
              result_r <= prod_sum;
              done_r   <= 1'b1;
              st_r     <= SQ_IDLE;
            end else begin
              rem_r <= '0;
              st_r  <= SQ_DIV;
            end
          end
        end
        SQ_DIV: begin
          rem_r  <= rem_nxt;
          prod_r <= prod_r << 1;
          step_r <= step_r + 1'b1;
          if (last_step) begin
            result_r <= rem_nxt;
            done_r   <= 1'b1;
            st_r     <= SQ_IDLE;
          end
        end
        default: st_r <= SQ_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

  `BBS_ASSERT(a_done_single, done_r |=> !done_r, "sqmod done held for more than one cycle")
  `BBS_ASSERT(a_start_idle, start |-> (st_r == SQ_IDLE), "sqmod started while busy")
  `BBS_ASSERT(a_idle_step, (st_r == SQ_IDLE) |-> (step_r == '0), "sqmod step count not cleared")

endmodule

FILE: rtl/bbs_random_bit_generator.sv
// top level of the blum blum shub random bit generator
//
//  channel   ports                                       handshake
//  input     in_func, in_seed_value, in_bit_count        start high, busy low
//  result    out_random_bits                             out_valid, one cycle
//  config    cfg_wr_data                                 cfg_wr_en
//
// a seed item loads the state and gives no result.
// a draw of n bits (n saturated to 64) is worked bit by bit:
// each bit is one pass of the serial unit, 64 multiply steps and 64 reduce steps.
// with a zero modulus the reduce steps are skipped.
// a zero-bit draw gives its result the cycle after it is taken.
// reset is synchronous; the receiver cannot stall, results are not held.
`include "bbs_random_bit_generator_assert.svh"

module bbs_random_bit_generator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_func,
  input  bbs_pkg::word_t  in_seed_value,
  input  bbs_pkg::count_t in_bit_count,
  output logic            out_valid,
  output bbs_pkg::word_t  out_random_bits,
  input  logic            cfg_wr_en,
  input  bbs_pkg::word_t  cfg_wr_data
);
  import bbs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t st_r;
  word_t  modulus_r;
  word_t  gen_state_r;
  word_t  acc_r;
  count_t remaining_r;
  logic   sq_start_r;
  logic   out_valid_r;
  word_t  out_bits_r;

  count_t draw_count;
  logic   sq_done;
  word_t  sq_result;
  word_t  acc_shift;

  assign draw_count = (in_bit_count > MAX_DRAW_BITS) ? MAX_DRAW_BITS : in_bit_count;
  assign acc_shift  = {acc_r[DATA_W-2:0], sq_result[0]};

  bbs_sqmod u_sqmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start_r),
    .operand (gen_state_r),
    .modulus (modulus_r),
    .done    (sq_done),
    .result  (sq_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      modulus_r   <= MODULUS_RESET;
      gen_state_r <= '0;
      remaining_r <= '0;
      sq_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
      case (st_r)
        ST_IDLE: begin
          if (start) begin
            if (func_t'(in_func) == FUNC_SEED) begin
              gen_state_r <= in_seed_value;
            end else if (draw_count == '0) begin
              out_valid_r <= 1'b1;
              out_bits_r  <= '0;
            end else begin
              remaining_r <= draw_count;
              acc_r       <= '0;
              sq_start_r  <= 1'b1;
              st_r        <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (sq_done) begin
            gen_state_r <= sq_result;
            acc_r       <= acc_shift;
            remaining_r <= remaining_r - 1'b1;
            if (remaining_r == count_t'(1)) begin
              out_valid_r <= 1'b1;
              out_bits_r  <= acc_shift;
              st_r        <= ST_IDLE;
            end else begin
              sq_start_r <= 1'b1;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (st_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_random_bits = out_bits_r;

  `BBS_ASSERT(a_seed_no_result, (start && !busy && (func_t'(in_func) == FUNC_SEED)) |=> !out_valid, "seed item gave a result")
  `BBS_ASSERT(a_run_count, (st_r == ST_RUN) |-> (remaining_r != '0), "draw running with no bits left")
  `BBS_ASSERT(a_done_in_run, sq_done |-> (st_r == ST_RUN), "square unit finished outside a draw")
  `BBS_ASSERT_RST(a_reset_quiet, !rst_n |=> (!busy && !out_valid), "block not quiet after reset")

endmodule
